### rtl/sli_pkg.sv
package sli_pkg;

    localparam int MODE_W   = 2;
    localparam int KEY_W    = 16;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 7;
    localparam int OFF_W    = 11;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [LEN_W-1:0]    len_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [OFF_W-1:0]    off_t;

    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_LOOKUP = 2'd1;
    localparam mode_t MODE_CLEAR  = 2'd2;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_NOT_FOUND  = 2'd1;
    localparam status_t ST_TABLE_FULL = 2'd2;
    localparam status_t ST_STORE_FULL = 2'd3;

    typedef struct packed {
        mode_t mode;
        key_t  line_number;
        len_t  text_length;
    } in_item_t;

    typedef struct packed {
        status_t status;
        idx_t    entry_index;
        off_t    text_offset;
    } out_item_t;

endpackage

### rtl/sli_stream_if.sv
interface sli_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/sli_ram.sv
module sli_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/sorted_line_index_table.sv
// channel | dir | item fields                                | handshake
// req     | in  | mode, line_number, text_length             | valid/ready
// rsp     | out | status, entry_index, text_offset           | valid/ready
//
// One item at a time. Clear and unused modes go from S_IDLE to S_FINISH; a
// lookup runs binary-search probes (up to 7 probes at depth 64) and, on a miss,
// a final S_PROBE_RD check. An insert adds S_WRITE for the entry write and, for
// a new number with room, S_SHIFT_RD and one S_SHIFT_WR per entry moved up.
// The single read port of the entry RAM splits each probe: read, then compare.
// Reset clears count, fill and the handshake; entries need no clearing pass.
// req is taken while a result waits in the rsp register; rsp stalls hold it.
module sorted_line_index_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int STORE_BYTES = 1024,
    parameter int LINE_BYTES  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    sli_stream_if.sink   req,
    sli_stream_if.source rsp
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int FW = $clog2(STORE_BYTES + 1);
    localparam int SW = ((FW > 9) ? FW : 9) + 1;
    localparam int MW = sli_pkg::KEY_W + FW;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_PROBE_RD = 7'b0000010,
        S_PROBE_CM = 7'b0000100,
        S_SHIFT_RD = 7'b0001000,
        S_SHIFT_WR = 7'b0010000,
        S_WRITE    = 7'b0100000,
        S_FINISH   = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    sli_pkg::mode_t       mode_reg, mode_next;
    sli_pkg::key_t        key_reg, key_next;
    logic [SW-1:0]        len_reg, len_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        hi_reg, hi_next;
    logic [CW-1:0]        mid_reg, mid_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        sh_reg, sh_next;
    logic                 grow_reg, grow_next;
    sli_pkg::status_t     res_status_reg, res_status_next;
    logic [CW-1:0]        res_idx_reg, res_idx_next;
    logic [FW-1:0]        res_off_reg, res_off_next;
    sli_pkg::out_item_t   rsp_data_reg, rsp_data_next;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [MW-1:0]        ram_wdata;
    logic [IW-1:0]        ram_raddr;
    logic [MW-1:0]        ram_rdata;

    logic [CW:0]          mid_sum;
    logic [CW-1:0]        mid_calc;
    logic [SW-1:0]        len_ext;
    logic [SW-1:0]        fill_sum;
    logic [CW-1:0]        sh_m1;
    logic [CW-1:0]        sh_m2;
    sli_pkg::key_t        probe_key;
    logic [FW-1:0]        probe_off;
    logic                 resolve;
    logic                 found;
    logic [CW-1:0]        found_pos;

    sli_ram #(
        .WIDTH (MW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg} - (CW+1)'(1);
    assign mid_calc  = mid_sum[CW:1];
    assign len_ext   = SW'(req.data.text_length);
    assign fill_sum  = SW'(fill_reg) + len_reg;
    assign sh_m1     = sh_reg - CW'(1);
    assign sh_m2     = sh_reg - CW'(2);
    assign probe_key = ram_rdata[FW +: sli_pkg::KEY_W];
    assign probe_off = ram_rdata[FW-1:0];

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        fill_next       = fill_reg;
        rsp_valid_next  = rsp_valid_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pos_next        = pos_reg;
        sh_next         = sh_reg;
        grow_next       = grow_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_off_next    = res_off_reg;
        rsp_data_next   = rsp_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg[IW-1:0];
        ram_wdata       = {key_reg, fill_reg};
        ram_raddr       = mid_calc[IW-1:0];
        resolve         = 1'b0;
        found           = 1'b0;
        found_pos       = lo_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next       = req.data.mode;
                    key_next        = req.data.line_number;
                    len_next        = (len_ext > SW'(LINE_BYTES + 1)) ?
                                      SW'(LINE_BYTES + 1) : len_ext;
                    lo_next         = '0;
                    hi_next         = count_reg;
                    res_status_next = sli_pkg::ST_OK;
                    res_idx_next    = '0;
                    res_off_next    = '0;
                    if (req.data.mode inside {sli_pkg::MODE_INSERT, sli_pkg::MODE_LOOKUP})
                    begin
                        state_next = S_PROBE_RD;
                    end
                    else
                    begin
                        if (req.data.mode == sli_pkg::MODE_CLEAR)
                        begin
                            count_next = '0;
                            fill_next  = '0;
                        end
                        state_next = S_FINISH;
                    end
                end
            end
            S_PROBE_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = S_PROBE_CM;
                end
                else
                begin
                    resolve = 1'b1;
                end
            end
            S_PROBE_CM:
            begin
                if (probe_key > key_reg)
                begin
                    hi_next    = mid_reg;
                    state_next = S_PROBE_RD;
                end
                else if (probe_key < key_reg)
                begin
                    lo_next    = mid_reg + CW'(1);
                    state_next = S_PROBE_RD;
                end
                else
                begin
                    resolve   = 1'b1;
                    found     = 1'b1;
                    found_pos = mid_reg;
                end
            end
            S_SHIFT_RD:
            begin
                ram_raddr  = sh_m1[IW-1:0];
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sh_reg[IW-1:0];
                ram_wdata = ram_rdata;
                ram_raddr = sh_m2[IW-1:0];
                sh_next   = sh_m1;
                if (sh_m1 == pos_reg)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ram_we       = 1'b1;
                count_next   = count_reg + CW'(grow_reg);
                res_idx_next = pos_reg;
                res_off_next = fill_reg;
                if (fill_sum > SW'(STORE_BYTES))
                begin
                    fill_next       = FW'(STORE_BYTES);
                    res_status_next = sli_pkg::ST_STORE_FULL;
                end
                else
                begin
                    fill_next       = fill_sum[FW-1:0];
                    res_status_next = sli_pkg::ST_OK;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.status      = res_status_reg;
                    rsp_data_next.entry_index = sli_pkg::idx_t'(res_idx_reg);
                    rsp_data_next.text_offset = sli_pkg::off_t'(res_off_reg);
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (resolve)
        begin
            pos_next     = found_pos;
            res_idx_next = found_pos;
            if (mode_reg == sli_pkg::MODE_LOOKUP)
            begin
                res_status_next = found ? sli_pkg::ST_OK : sli_pkg::ST_NOT_FOUND;
                res_off_next    = found ? probe_off : '0;
                state_next      = S_FINISH;
            end
            else if (found)
            begin
                grow_next  = 1'b0;
                state_next = S_WRITE;
            end
            else if (count_reg == CW'(TABLE_DEPTH))
            begin
                res_status_next = sli_pkg::ST_TABLE_FULL;
                res_off_next    = '0;
                state_next      = S_FINISH;
            end
            else
            begin
                grow_next  = 1'b1;
                sh_next    = count_reg;
                state_next = (found_pos == count_reg) ? S_WRITE : S_SHIFT_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        pos_reg        <= pos_next;
        sh_reg         <= sh_next;
        grow_reg       <= grow_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_off_reg    <= res_off_next;
        rsp_data_reg   <= rsp_data_next;
    end

endmodule

### rtl/sli_chk.sv
module sli_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input sli_pkg::out_item_t rsp_data
);

    logic [1:0] pending_reg, pending_next;

    always_comb
    begin
        pending_next = pending_reg + 2'(req_valid && req_ready)
                       - 2'(rsp_valid && rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("rsp item changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 2'd0)
        else $error("rsp item without a matching req item");

    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd3)
        else $error("too many items in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.status == sli_pkg::ST_NOT_FOUND ||
                      rsp_data.status == sli_pkg::ST_TABLE_FULL)
        |-> rsp_data.text_offset == '0)
        else $error("offset reported on a miss");

endmodule

bind sorted_line_index_table sli_chk u_sli_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
